// ===== src/mtg_pkg.sv =====
// Shared constants and types of the MT19937 generator.
// Used by the twist-table memory and by the top level; depends on nothing.
package mtg_pkg;

    localparam int TABLE_WORDS = 624;
    localparam int TWIST_MID   = 397;
    localparam int PTR_W       = $clog2(TABLE_WORDS);

    localparam logic [31:0] TWIST_XOR = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B  = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C  = 32'hefc60000;

    // reset contents: the first TABLE_WORDS primes, the last one is 4621
    localparam int PRIME_LIMIT = 4621;
    localparam int PRIME_W     = $clog2(PRIME_LIMIT + 1);

    // item kinds carried in tuser
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_DRAW32 = 2'd1;
    localparam logic [1:0] KIND_DRAW64 = 2'd2;

    // result buffer depth (power of two)
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        logic [31:0]      data;
    } mtg_wr_t;

    typedef struct packed {
        logic [PTR_W-1:0] a_addr;
        logic [PTR_W-1:0] b_addr;
    } mtg_rd_t;

endpackage

// ===== src/mersenne_twister_generator_top.sv =====
// Top level of the MT19937 generator: input decode, twist pipeline, tempering
// and result buffer. Depends on mtg_pkg and mtg_table.
//
// Usage:
//   Input stream s_*: tuser carries the kind (load word, 32-bit draw, 64-bit
//   draw); tdata carries load_index and load_word. Result stream m_*: tdata
//   carries random_value, one transfer per draw, none for loads or kind 3.
//   Each drawn word is one read-modify-write of the twist table: reads of
//   words p+1 and p+397 on the two memory ports, write of word p in the next cycle,
//   word p itself held in a register from the previous draw.
//   A 32-bit draw is taken every cycle while s_tready is high; a 64-bit
//   draw twists two words in turn, and no item is taken while the second is
//   issued. Each word passes the issue and execute stages; the first word of
//   a 64-bit draw waits in hi_reg, then the result goes to the result buffer.
//   After a load the next item waits while the load's write completes and
//   word 0 is fetched again. After reset the block fills the table with the
//   first 624 primes, one word a cycle, then fetches word 0; s_tready stays low until then.
//   When the receiver stalls, up to four results wait in the result buffer;
//   s_tready drops once four results are outstanding.
module mersenne_twister_generator_top
    import mtg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [9:0] load_index, [41:10] load_word, [47:42] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] random_value
);

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_PRIME = 2'd1;
    localparam logic [1:0] OP_DRAW  = 2'd2;
    localparam logic [1:0] OP_LOAD  = 2'd3;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    logic [1:0]       kind;
    logic [PTR_W-1:0] load_index;
    logic [31:0]      load_word;

    assign kind       = s_tuser;
    assign load_index = s_tdata[PTR_W-1:0];
    assign load_word  = s_tdata[41:10];

    // issue stage
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             cur_ok_reg, cur_ok_next;
    logic             pend_lo_reg, pend_lo_next;
    logic [OUT_PTR_W:0] cred_reg, cred_next;
    logic [PTR_W-1:0] ptr_inc, ptr_mid;
    logic [PTR_W:0]   mid_sum, mid_wrap;
    logic             busy, s_acc, acc_draw, acc_wide, acc_load, word_go, prime_go;

    // execute stage
    logic [1:0]       e_op_reg, e_op_next;
    logic             e_hi_reg, e_hi_next;
    logic             e_wide_reg, e_wide_next;
    logic             e_ldok_reg, e_ldok_next;
    logic [PTR_W-1:0] e_addr_reg, e_addr_next;
    logic [31:0]      e_ldword_reg, e_ldword_next;
    logic [31:0]      cur_reg, hi_reg;
    logic [31:0]      rd_a_data, rd_b_data, mix, twisted, tempered;
    logic             e_push;

    // result buffer
    logic [63:0]          ofifo [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] o_wr_ptr_reg, o_rd_ptr_reg;
    logic [OUT_PTR_W:0]   ocnt_reg, ocnt_next;
    logic                 pop;

    mtg_wr_t wr;
    mtg_rd_t rd;

    assign ptr_inc  = (ptr_reg == PTR_W'(TABLE_WORDS - 1)) ? '0 : ptr_reg + 1'b1;
    assign mid_sum  = {1'b0, ptr_reg} + (PTR_W + 1)'(TWIST_MID);
    assign mid_wrap = mid_sum - (PTR_W + 1)'(TABLE_WORDS);
    assign ptr_mid  = (mid_sum >= (PTR_W + 1)'(TABLE_WORDS)) ? mid_wrap[PTR_W-1:0]
                                                              : mid_sum[PTR_W-1:0];

    assign s_tready = !busy && cur_ok_reg && !pend_lo_reg
                      && (cred_reg < (OUT_PTR_W + 1)'(OUT_DEPTH));
    assign s_acc    = s_tvalid && s_tready;
    assign acc_wide = s_acc && (kind == KIND_DRAW64);
    assign acc_draw = s_acc && ((kind == KIND_DRAW32) || (kind == KIND_DRAW64));
    assign acc_load = s_acc && (kind == KIND_LOAD);
    assign word_go  = acc_draw || pend_lo_reg;
    // fetch word p after reset or a load; wait until a load's own write is done
    assign prime_go = !busy && !cur_ok_reg && (e_op_reg != OP_LOAD);

    assign rd.a_addr = prime_go ? ptr_reg : ptr_inc;
    assign rd.b_addr = ptr_mid;

    always_comb begin
        ptr_next      = ptr_reg;
        cur_ok_next   = cur_ok_reg;
        pend_lo_next  = acc_wide;
        e_op_next     = OP_NONE;
        e_hi_next     = 1'b0;
        e_wide_next   = pend_lo_reg;
        e_ldok_next   = load_index < PTR_W'(TABLE_WORDS);
        e_addr_next   = ptr_reg;
        e_ldword_next = load_word;
        if (word_go) begin
            e_op_next = OP_DRAW;
            e_hi_next = acc_wide;
            ptr_next  = ptr_inc;
        end else if (prime_go) begin
            e_op_next   = OP_PRIME;
            cur_ok_next = 1'b1;
        end else if (acc_load) begin
            e_op_next   = OP_LOAD;
            e_addr_next = load_index;
            ptr_next    = '0;
            cur_ok_next = 1'b0;
        end
    end

    assign cred_next = cred_reg + (OUT_PTR_W + 1)'(acc_draw) - (OUT_PTR_W + 1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            cur_ok_reg  <= 1'b0;
            pend_lo_reg <= 1'b0;
            cred_reg    <= '0;
            e_op_reg    <= OP_NONE;
        end else begin
            ptr_reg     <= ptr_next;
            cur_ok_reg  <= cur_ok_next;
            pend_lo_reg <= pend_lo_next;
            cred_reg    <= cred_next;
            e_op_reg    <= e_op_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_hi_reg     <= e_hi_next;
        e_wide_reg   <= e_wide_next;
        e_ldok_reg   <= e_ldok_next;
        e_addr_reg   <= e_addr_next;
        e_ldword_reg <= e_ldword_next;
    end

    mtg_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .rd        (rd),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data),
        .busy      (busy)
    );

    // twist word p from its upper bit, word p+1 and word p+397
    assign mix      = {cur_reg[31], rd_a_data[30:0]};
    assign twisted  = rd_b_data ^ (mix >> 1) ^ (mix[0] ? TWIST_XOR : 32'h0);
    assign tempered = temper(twisted);

    always_comb begin
        wr.en   = 1'b0;
        wr.addr = e_addr_reg;
        wr.data = twisted;
        if (e_op_reg == OP_DRAW) begin
            wr.en = 1'b1;
        end else if (e_op_reg == OP_LOAD) begin
            wr.en   = e_ldok_reg;
            wr.data = e_ldword_reg;
        end
    end

    // word p+1 (word p after a refetch) becomes the held word for the next draw; hi_reg keeps a 64-bit draw's high half
    always_ff @(posedge aclk) begin
        if ((e_op_reg == OP_DRAW) || (e_op_reg == OP_PRIME)) begin
            cur_reg <= rd_a_data;
        end
        if ((e_op_reg == OP_DRAW) && e_hi_reg) begin
            hi_reg <= tempered;
        end
    end

    assign e_push = (e_op_reg == OP_DRAW) && !e_hi_reg;

    assign m_tvalid  = ocnt_reg != '0;
    assign m_tdata   = ofifo[o_rd_ptr_reg];
    assign pop       = m_tvalid && m_tready;
    assign ocnt_next = ocnt_reg + (OUT_PTR_W + 1)'(e_push) - (OUT_PTR_W + 1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_wr_ptr_reg <= '0;
            o_rd_ptr_reg <= '0;
            ocnt_reg     <= '0;
        end else begin
            ocnt_reg <= ocnt_next;
            if (e_push) begin
                o_wr_ptr_reg <= o_wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                o_rd_ptr_reg <= o_rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (e_push) begin
            ofifo[o_wr_ptr_reg] <= {(e_wide_reg ? hi_reg : 32'h0), tempered};
        end
    end

    // buffer space was reserved when the draw was taken
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        e_push |-> (ocnt_reg < (OUT_PTR_W + 1)'(OUT_DEPTH)))
        else $error("result buffer overflow");

    a_credit_covers_buffer: assert property (@(posedge aclk) disable iff (!aresetn)
        ocnt_reg <= cred_reg)
        else $error("result credit below buffer fill");

    a_draw_has_word: assert property (@(posedge aclk) disable iff (!aresetn)
        word_go |-> cur_ok_reg && !busy)
        else $error("draw issued without held word p");

    a_load_refetch: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_load |=> !s_tready)
        else $error("input taken before word 0 refetch after load");

endmodule

// ===== src/mtg_table.sv =====
// Twist table: 624 x 32 memory, one write port and two registered read ports.
// After reset it sweeps the prime list into the memory and reports busy.
// Depends on mtg_pkg.
module mtg_table
    import mtg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  mtg_wr_t     wr,
    input  mtg_rd_t     rd,
    output logic [31:0] rd_a_data,
    output logic [31:0] rd_b_data,
    output logic        busy
);

    typedef logic [PRIME_W-1:0] prime_rom_t [TABLE_WORDS];

    // sieve of Eratosthenes, evaluated at elaboration
    function automatic prime_rom_t build_primes();
        logic [PRIME_LIMIT:0] composite;
        prime_rom_t           rom;
        int                   k;
        composite = '0;
        k = 0;
        for (int i = 0; i < TABLE_WORDS; i++) begin
            rom[i] = '0;
        end
        for (int n = 2; n <= PRIME_LIMIT; n++) begin
            if (!composite[n]) begin
                if (k < TABLE_WORDS) begin
                    rom[k] = PRIME_W'(n);
                end
                k++;
                for (int m = n + n; m <= PRIME_LIMIT; m += n) begin
                    composite[m] = 1'b1;
                end
            end
        end
        return rom;
    endfunction

    localparam prime_rom_t PRIME_ROM = build_primes();

    logic [31:0]        mem [TABLE_WORDS];
    logic [PTR_W-1:0]   init_cnt_reg;
    logic [PTR_W-1:0]   init_cnt_next;
    logic               rom_wv_reg;
    logic               rom_wv_next;
    logic [PRIME_W-1:0] rom_q_reg;
    logic [PTR_W-1:0]   rom_wa_reg;
    logic               sweep_on;

    assign sweep_on      = init_cnt_reg < PTR_W'(TABLE_WORDS);
    assign init_cnt_next = sweep_on ? init_cnt_reg + 1'b1 : init_cnt_reg;
    assign rom_wv_next   = sweep_on;
    assign busy          = sweep_on | rom_wv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_cnt_reg <= '0;
            rom_wv_reg   <= 1'b0;
        end else begin
            init_cnt_reg <= init_cnt_next;
            rom_wv_reg   <= rom_wv_next;
        end
    end

    // registered ROM read ahead of the sweep write
    always_ff @(posedge aclk) begin
        if (sweep_on) begin
            rom_q_reg  <= PRIME_ROM[init_cnt_reg];
            rom_wa_reg <= init_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rom_wv_reg) begin
            mem[rom_wa_reg] <= {{(32 - PRIME_W){1'b0}}, rom_q_reg};
        end else if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_a_data <= mem[rd.a_addr];
        rd_b_data <= mem[rd.b_addr];
    end

endmodule

// ===== tb/tb_mersenne_twister_generator_top.sv =====
// Self-checking testbench for the MT19937 generator top level.
// Predicts every draw from its own copy of the twist table and checks the result stream.
// Depends on mtg_pkg and the generator RTL only.
module tb_mersenne_twister_generator_top
    import mtg_pkg::*;
();

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 560;
    localparam int WRAP_ITEMS = 460;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = KIND_DRAW32;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    // predictor state
    logic [31:0] twist_words [TABLE_WORDS];
    int unsigned word_ptr;
    logic [63:0] expected_values [$];

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  steady_flow = 1'b0;

    mersenne_twister_generator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void fill_prime_table();
        int unsigned cand;
        int unsigned count;
        int unsigned d;
        bit is_prime;
        cand = 2;
        count = 0;
        while (count < TABLE_WORDS) begin
            is_prime = 1'b1;
            for (d = 2; d * d <= cand; d++) begin
                if (cand % d == 0) begin
                    is_prime = 1'b0;
                    break;
                end
            end
            if (is_prime) begin
                twist_words[count] = cand;
                count++;
            end
            cand++;
        end
        word_ptr = 0;
    endfunction

    function automatic logic [31:0] temper_word(input logic [31:0] raw);
        logic [31:0] y;
        y = raw;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // twist the word at the pointer in place, advance, return it tempered
    function automatic logic [31:0] draw_twisted_word();
        int unsigned p;
        int unsigned nxt;
        int unsigned mid;
        logic [31:0] mix;
        logic [31:0] y;
        p = word_ptr;
        nxt = (p + 1) % TABLE_WORDS;
        mid = (p + TWIST_MID) % TABLE_WORDS;
        mix = {twist_words[p][31], twist_words[nxt][30:0]};
        y = twist_words[mid] ^ (mix >> 1) ^ (mix[0] ? TWIST_XOR : 32'h0);
        twist_words[p] = y;
        word_ptr = nxt;
        return temper_word(y);
    endfunction

    function automatic void predict_item(input logic [1:0] kind, input logic [9:0] index,
                                         input logic [31:0] word);
        logic [31:0] hi;
        logic [31:0] lo;
        case (kind)
            KIND_LOAD: begin
                if (index < TABLE_WORDS)
                    twist_words[index] = word;
                word_ptr = 0;
            end
            KIND_DRAW32: begin
                lo = draw_twisted_word();
                expected_values.push_back({32'h0, lo});
            end
            KIND_DRAW64: begin
                hi = draw_twisted_word();
                lo = draw_twisted_word();
                expected_values.push_back({hi, lo});
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [9:0] index,
                             input logic [31:0] word);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, word, index};
        do @(posedge aclk); while (!s_tready);
        predict_item(kind, index, word);
    endtask

    task automatic send_random_item(input int load_pct, input int unused_pct);
        int roll;
        logic [1:0] kind;
        logic [9:0] index;
        roll = $urandom_range(0, 99);
        if (roll < load_pct)
            kind = KIND_LOAD;
        else if (roll < load_pct + unused_pct)
            kind = KIND_UNUSED;
        else
            kind = ($urandom_range(0, 1) == 0) ? KIND_DRAW32 : KIND_DRAW64;
        if ($urandom_range(0, 9) == 0)
            index = 10'($urandom_range(TABLE_WORDS, 1023));
        else
            index = 10'($urandom_range(0, TABLE_WORDS - 1));
        send_item(kind, index, $urandom());
    endtask

    // hold the sender until every expected result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic test_prime_table_draws();
        send_item(KIND_DRAW32, 10'h000, 32'h0000_0000);
        send_item(KIND_DRAW32, 10'h3ff, 32'hffff_ffff);
        send_item(KIND_DRAW64, 10'h155, 32'haaaa_aaaa);
        send_item(KIND_DRAW64, 10'h2aa, 32'h5555_5555);
        send_item(KIND_DRAW32, 10'h000, 32'h0000_0000);
    endtask

    task automatic test_load_extremes();
        send_item(KIND_LOAD, 10'd0, 32'h0000_0000);
        send_item(KIND_LOAD, 10'd623, 32'hffff_ffff);
        send_item(KIND_DRAW32, 10'd0, 32'h0);
        send_item(KIND_LOAD, 10'd624, 32'hdead_beef);
        send_item(KIND_DRAW64, 10'd0, 32'h0);
        send_item(KIND_LOAD, 10'd1023, 32'hffff_ffff);
        send_item(KIND_LOAD, 10'd1, 32'h8000_0001);
        send_item(KIND_DRAW32, 10'd0, 32'h0);
        // unused kind: no effect on table or pointer
        send_item(KIND_UNUSED, 10'h3ff, 32'hffff_ffff);
        send_item(KIND_UNUSED, 10'h000, 32'h0000_0000);
        send_item(KIND_DRAW64, 10'd0, 32'h0);
    endtask

    task automatic test_drain_pause();
        repeat (6) send_item(KIND_DRAW64, 10'd0, 32'h0);
        wait_drained();
        send_item(KIND_DRAW32, 10'd0, 32'h0);
        send_item(KIND_DRAW64, 10'd0, 32'h0);
    endtask

    task automatic test_random_traffic();
        int n;
        // no loads at first, only draws and unused items, so the pointer wraps around the table
        for (n = 0; n < WRAP_ITEMS; n++) begin
            steady_flow = (n >= 200 && n < 260);
            send_random_item(0, 3);
        end
        steady_flow = 1'b0;
        for (n = WRAP_ITEMS; n < RANDOM_ITEMS; n++) begin
            steady_flow = (n >= 480 && n < 520);
            if (n == 530)
                wait_drained();
            send_random_item(6, 3);
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_zero_table();
        int n;
        steady_flow = 1'b1;
        for (n = 0; n < TABLE_WORDS; n++)
            send_item(KIND_LOAD, 10'(n), 32'h0);
        steady_flow = 1'b0;
        send_item(KIND_DRAW32, 10'd0, 32'h0);
        send_item(KIND_DRAW64, 10'd0, 32'h0);
        send_item(KIND_DRAW32, 10'd0, 32'h0);
    endtask

    initial begin
        fill_prime_table();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_prime_table_draws();
        test_load_extremes();
        test_drain_pause();
        test_random_traffic();
        test_zero_table();
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && expected_values.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result receiver with random backpressure
    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        logic [63:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_values.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result transfer: got %h", m_tdata);
            end else begin
                want = expected_values.pop_front();
                if (m_tdata !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("random_value mismatch: expected %h, got %h", want, m_tdata);
                end
            end
        end
    end

    // abort when no transfer happens on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
src/mtg_pkg.sv
src/mtg_table.sv
src/mersenne_twister_generator_top.sv
tb/tb_mersenne_twister_generator_top.sv
